>>> src/obs_pkg.sv
// ----------------------------------------------------------------------------
// obs_pkg
// Shared types and constants for the online boosting selector.
// ----------------------------------------------------------------------------
package obs_pkg;

  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [31:0] SAT32        = 32'hFFFF_FFFF;
  localparam logic [31:0] LN2_HALF_Q32 = 32'd1488522236;
  localparam logic [23:0] VOTE_MAX     = 24'h7F_FFFF;
  localparam logic [23:0] VOTE_MIN     = 24'h80_0000;
  localparam logic [16:0] ERR_ONE      = 17'h1_0000;

  // Request to the shared restoring divider. The caller guarantees rem0 < divisor.
  typedef struct packed {
    logic        start;
    logic [33:0] rem0;
    logic [47:0] dq0;
    logic [33:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
  } unit_sts_t;

  typedef struct packed {
    logic        start;
    logic [15:0] value;
  } log_req_t;

endpackage

>>> src/obs_ram.sv
// ----------------------------------------------------------------------------
// obs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module obs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/obs_div.sv
// ----------------------------------------------------------------------------
// obs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module obs_div
  import obs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output unit_sts_t   sts,
  output logic [47:0] quo
);

  logic [33:0] rem_r;
  logic [47:0] dq_r;
  logic [47:0] quo_r;
  logic [33:0] div_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [34:0] rem_sh;
  logic        qbit;
  logic [34:0] rem_sub;

  assign rem_sh  = {rem_r, dq_r[47]};
  assign qbit    = rem_sh >= {1'b0, div_r};
  assign rem_sub = qbit ? (rem_sh - {1'b0, div_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem0;
      dq_r  <= req.dq0;
      div_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_sub[33:0];
      dq_r  <= {dq_r[46:0], 1'b0};
      quo_r <= {quo_r[46:0], qbit};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

>>> src/obs_log.sv
// ----------------------------------------------------------------------------
// obs_log
// Base-two logarithm in Q4.24 by repeated squaring of the mantissa.
// ----------------------------------------------------------------------------
module obs_log
  import obs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  log_req_t    req,
  output unit_sts_t   sts,
  output logic [27:0] result
);

  logic [31:0] m_r;
  logic [27:0] res_r;
  logic [4:0]  bit_r;
  logic        busy_r;
  logic        done_r;
  logic [3:0]  msb;
  logic [63:0] prod;
  logic [32:0] sq;

  // Position of the leading one; an input of zero gives position zero.
  always_comb begin
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (req.value[i]) begin
        msb = 4'(i);
      end
    end
  end

  assign prod = 64'(m_r) * 64'(m_r);
  assign sq   = prod[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        bit_r  <= 5'd23;
      end else if (busy_r) begin
        bit_r <= bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      m_r   <= 32'(req.value) << (5'd31 - {1'b0, msb});
      res_r <= {msb, 24'd0};
    end else if (busy_r) begin
      if (sq[32]) begin
        m_r          <= sq[32:1];
        res_r[bit_r] <= 1'b1;
      end else begin
        m_r <= sq[31:0];
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = res_r;

endmodule

>>> src/online_boost_selector.sv
// ----------------------------------------------------------------------------
// online_boost_selector
// One online boosting round: weight update, best/worst search, lambda
// rescale and voting weight, on one shared divider and one log unit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    masks and importance
// out_      output     out_valid / out_ready  indexes, flags, lambda, vote, error
// cfg_      input      cfg_valid / cfg_ready  active slot count
//
// Each unselected active slot takes a RAM read, an update, 17 divider steps
// (skipped when its weights sum to zero) and a compare; a selected slot only
// the read and the update. With a best slot, the lambda division (48 divider
// steps), two 24-step logarithms and the vote product follow. The shared divider takes most of a round.
// Reset is synchronous and active low; weights are undefined until a slot's
// new bit is seen. in_ready is high only while idle; a finished result waits
// in the output register and a new request may be taken meanwhile.
// ----------------------------------------------------------------------------
module online_boost_selector
  import obs_pkg::*;
#(
  parameter int MAX_WEAK = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_new_mask,
  input  logic [31:0] in_correct_mask,
  input  logic [31:0] in_selected_mask,
  input  logic [31:0] in_importance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_best_index,
  output logic        out_best_valid,
  output logic [4:0]  out_worst_index,
  output logic        out_worst_valid,
  output logic [31:0] out_updated_importance,
  output logic [23:0] out_vote_weight,
  output logic [16:0] out_best_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  localparam int AW    = $clog2(MAX_WEAK);
  localparam int LIMIT = (MAX_WEAK < 32) ? MAX_WEAK : 32;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_UPD, S_DIV, S_CMP, S_LAM, S_LAMW,
    S_LOGA, S_LOGAW, S_LOGB, S_LOGBW, S_MUL, S_RND, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  active_r;
  logic [5:0]  n_r, n_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] nmask_r, cmask_r, smask_r, lam_r;
  logic [16:0] min_r, min_nxt, max_r, max_nxt, err_r, err_nxt;
  logic [4:0]  best_r, best_nxt, worst_r, worst_nxt;
  logic        bok_r, bok_nxt, wok_r, wok_nxt;
  logic [31:0] nl_r, nl_nxt;
  logic [27:0] la_r, la_nxt;
  logic [27:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [59:0] prod_r, prod_nxt;
  logic [23:0] vote_r, vote_nxt;
  logic [4:0]  chosen_r, chosen_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [4:0]  out_best_r, out_worst_r;
  logic        out_bok_r, out_wok_r;
  logic [31:0] out_lam_r;
  logic [23:0] out_vote_r;
  logic [16:0] out_err_r;

  logic [4:0]  slot;
  logic [31:0] right_rd, miss_rd, right_upd, miss_upd, right_base, miss_base;
  logic [32:0] right_sum, miss_sum, wsum;
  logic        ram_we;
  logic [5:0]  n_eff;

  div_req_t    div_req;
  unit_sts_t   div_sts;
  logic [47:0] div_quo;
  log_req_t    log_req;
  unit_sts_t   log_sts;
  logic [27:0] log_res;

  logic [17:0] lam_div;
  logic [28:0] diff;
  logic [23:0] rnd;
  logic [59:0] rnd_sum;

  assign slot = cnt_r[4:0];
  assign n_eff = (active_r > 6'(LIMIT)) ? 6'(LIMIT) : active_r;

  obs_ram #(.WIDTH(32), .DEPTH(MAX_WEAK)) u_right_ram (
    .clk(clk), .we(ram_we), .waddr(AW'(cnt_r)), .wdata(right_upd),
    .raddr(AW'(cnt_r)), .rdata(right_rd)
  );

  obs_ram #(.WIDTH(32), .DEPTH(MAX_WEAK)) u_miss_ram (
    .clk(clk), .we(ram_we), .waddr(AW'(cnt_r)), .wdata(miss_upd),
    .raddr(AW'(cnt_r)), .rdata(miss_rd)
  );

  obs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .sts(div_sts), .quo(div_quo));

  obs_log u_log (.clk(clk), .rst_n(rst_n), .req(log_req), .sts(log_sts), .result(log_res));

  // Weight update for the slot whose stored weights were just read.
  always_comb begin
    right_base = nmask_r[slot] ? ONE_Q16 : right_rd;
    miss_base  = nmask_r[slot] ? ONE_Q16 : miss_rd;
    right_sum  = {1'b0, right_base} + {1'b0, lam_r};
    miss_sum   = {1'b0, miss_base} + {1'b0, lam_r};
    right_upd  = right_base;
    miss_upd   = miss_base;
    if (cmask_r[slot]) begin
      right_upd = right_sum[32] ? SAT32 : right_sum[31:0];
    end else begin
      miss_upd = miss_sum[32] ? SAT32 : miss_sum[31:0];
    end
    wsum = {1'b0, right_upd} + {1'b0, miss_upd};
  end

  assign lam_div = cmask_r[best_r] ? {(ERR_ONE - min_r), 1'b0} : {min_r, 1'b0};
  assign diff    = {1'b0, la_r} - {1'b0, log_res};
  assign rnd_sum = prod_r + {20'd0, 1'b1, 39'd0};
  assign rnd     = {4'd0, rnd_sum[59:40]};

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    err_nxt       = err_r;
    best_nxt      = best_r;
    worst_nxt     = worst_r;
    bok_nxt       = bok_r;
    wok_nxt       = wok_r;
    nl_nxt        = nl_r;
    la_nxt        = la_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    vote_nxt      = vote_r;
    chosen_nxt    = chosen_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    div_req       = '0;
    log_req       = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = n_eff;
          cnt_nxt   = '0;
          min_nxt   = ERR_ONE;
          max_nxt   = '0;
          best_nxt  = '0;
          worst_nxt = '0;
          bok_nxt   = 1'b0;
          wok_nxt   = 1'b0;
          state_nxt = (n_eff == 6'd0) ? S_LAM : S_RD;
        end
      end
      S_RD: state_nxt = S_UPD;
      S_UPD: begin
        ram_we = 1'b1;
        if (smask_r[slot]) begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = (cnt_r + 6'd1 == n_r) ? S_LAM : S_RD;
        end else if (wsum == 33'd0) begin
          err_nxt   = ERR_ONE;
          state_nxt = S_CMP;
        end else begin
          // Quotient is below 2^17, so only its low 17 bits are developed.
          div_req.start   = 1'b1;
          div_req.rem0    = {3'd0, miss_upd[31:1]};
          div_req.dq0     = {miss_upd[0], 47'd0};
          div_req.divisor = {1'b0, wsum};
          div_req.steps   = 6'd17;
          state_nxt       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          err_nxt   = div_quo[16:0];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (err_r < min_r) begin
          min_nxt  = err_r;
          best_nxt = slot;
          bok_nxt  = 1'b1;
        end else if (err_r >= max_r) begin
          max_nxt   = err_r;
          worst_nxt = slot;
          wok_nxt   = 1'b1;
        end
        cnt_nxt   = cnt_r + 6'd1;
        state_nxt = (cnt_r + 6'd1 == n_r) ? S_LAM : S_RD;
      end
      S_LAM: begin
        if (!bok_r) begin
          nl_nxt    = lam_r;
          state_nxt = S_OUT;
        end else if (lam_div == 18'd0) begin
          nl_nxt    = (lam_r != 32'd0) ? SAT32 : 32'd0;
          state_nxt = S_LOGA;
        end else begin
          div_req.start   = 1'b1;
          div_req.rem0    = '0;
          div_req.dq0     = {lam_r, 16'd0};
          div_req.divisor = {16'd0, lam_div};
          div_req.steps   = 6'd48;
          state_nxt       = S_LAMW;
        end
      end
      S_LAMW: begin
        if (div_sts.done) begin
          nl_nxt    = (div_quo[47:32] != 16'd0) ? SAT32 : div_quo[31:0];
          state_nxt = S_LOGA;
        end
      end
      S_LOGA: begin
        chosen_nxt = best_r;
        if (min_r == 17'd0) begin
          vote_nxt  = VOTE_MAX;
          state_nxt = S_OUT;
        end else begin
          log_req.start = 1'b1;
          log_req.value = 16'(ERR_ONE - min_r);
          state_nxt     = S_LOGAW;
        end
      end
      S_LOGAW: begin
        if (log_sts.done) begin
          la_nxt    = log_res;
          state_nxt = S_LOGB;
        end
      end
      S_LOGB: begin
        log_req.start = 1'b1;
        log_req.value = min_r[15:0];
        state_nxt     = S_LOGBW;
      end
      S_LOGBW: begin
        if (log_sts.done) begin
          neg_nxt   = diff[28];
          mag_nxt   = diff[28] ? 28'(-diff) : diff[27:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = 60'(mag_r) * 60'(LN2_HALF_Q32);
        state_nxt = S_RND;
      end
      S_RND: begin
        if (neg_r) begin
          vote_nxt = (rnd > 24'h80_0000) ? VOTE_MIN : (24'd0 - rnd);
        end else begin
          vote_nxt = (rnd > 24'h7F_FFFF) ? VOTE_MAX : rnd;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 6'd32;
      out_valid_r <= 1'b0;
      vote_r      <= '0;
      chosen_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vote_r      <= vote_nxt;
      chosen_r    <= chosen_nxt;
      if (cfg_valid) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      nmask_r <= in_new_mask;
      cmask_r <= in_correct_mask;
      smask_r <= in_selected_mask;
      lam_r   <= in_importance;
    end
    n_r     <= n_nxt;
    cnt_r   <= cnt_nxt;
    min_r   <= min_nxt;
    max_r   <= max_nxt;
    err_r   <= err_nxt;
    best_r  <= best_nxt;
    worst_r <= worst_nxt;
    bok_r   <= bok_nxt;
    wok_r   <= wok_nxt;
    nl_r    <= nl_nxt;
    la_r    <= la_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_best_r  <= bok_r ? best_r : chosen_r;
      out_bok_r   <= bok_r;
      out_worst_r <= wok_r ? worst_r : 5'd0;
      out_wok_r   <= wok_r;
      out_lam_r   <= nl_r;
      out_vote_r  <= vote_r;
      out_err_r   <= min_r;
    end
  end

  assign in_ready               = (state_r == S_IDLE);
  assign cfg_ready              = 1'b1;
  assign out_valid              = out_valid_r;
  assign out_best_index         = out_best_r;
  assign out_best_valid         = out_bok_r;
  assign out_worst_index        = out_worst_r;
  assign out_worst_valid        = out_wok_r;
  assign out_updated_importance = out_lam_r;
  assign out_vote_weight        = out_vote_r;
  assign out_best_error         = out_err_r;

`ifndef SYNTHESIS
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_sts.busy) else $error("divider restarted while busy");
  a_best_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_best_valid |-> out_best_error < ERR_ONE)
    else $error("best slot reported with full error");
  a_no_best_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_best_valid |-> out_best_error == ERR_ONE)
    else $error("no best slot but error below one");
  a_worst_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_worst_valid |-> out_worst_index == 5'd0)
    else $error("worst index set without a worst slot");
`endif

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Online boosting selector testbench
// Drives directed rounds, then random rounds with random masks and importance
// values, under random back-pressure, and checks every result against a
// predictor of the rounds. Slot counts, extremes among them, vary by phase.
// ----------------------------------------------------------------------------
module testbench;
  import obs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]  best_index;
    logic        best_valid;
    logic [4:0]  worst_index;
    logic        worst_valid;
    logic [31:0] updated_importance;
    logic [23:0] vote_weight;
    logic [16:0] best_error;
  } round_result_t;

  class round_tracker;
    logic [31:0]   right_w [32];
    logic [31:0]   miss_w [32];
    logic [23:0]   vote_keep;
    logic [4:0]    pick_keep;
    int            slots;
    int            errors;
    round_result_t expected_q[$];

    function new();
      vote_keep = '0;
      pick_keep = '0;
      slots = 32;
      errors = 0;
      foreach (right_w[i]) begin
        right_w[i] = '0;
        miss_w[i] = '0;
      end
    endfunction

    function logic [31:0] log2_q24(logic [31:0] v);
      int k;
      longint unsigned m;
      logic [31:0] r;
      k = 0;
      if (v == 0) return 0;
      while (k < 31 && (v >> (k + 1)) != 0) k++;
      m = longint'(v) << (31 - k);
      r = k << 24;
      for (int b = 23; b >= 0; b--) begin
        m = (m * m) >> 31;
        if (m >= 64'h1_0000_0000) begin
          r[b] = 1'b1;
          m = m >> 1;
        end
      end
      return r;
    endfunction

    function logic [23:0] vote_from_error(logic [31:0] e);
      longint diff;
      longint unsigned mag, r;
      if (e == 0) return VOTE_MAX;
      diff = longint'(log2_q24(ONE_Q16 - e)) - longint'(log2_q24(e));
      mag = (diff < 0) ? -diff : diff;
      r = (mag * LN2_HALF_Q32 + (64'd1 << 39)) >> 40;
      if (diff < 0) return (r > 64'h80_0000) ? VOTE_MIN : 24'(-r);
      return (r > 64'h7F_FFFF) ? VOTE_MAX : 24'(r);
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = a + b;
      return s[32] ? SAT32 : s[31:0];
    endfunction

    function void note_round(logic [31:0] newm, logic [31:0] corm,
                             logic [31:0] selm, logic [31:0] lambda);
      round_result_t res;
      longint unsigned sum, err, min_err, max_err, d, q;
      int n, best, worst;
      bit best_ok, worst_ok;
      n = (slots > 32) ? 32 : slots;
      min_err = ONE_Q16;
      max_err = 0;
      best = 0;
      worst = 0;
      best_ok = 0;
      worst_ok = 0;
      res.updated_importance = lambda;
      res.vote_weight = vote_keep;
      for (int i = 0; i < n; i++) begin
        if (newm[i]) begin
          right_w[i] = ONE_Q16;
          miss_w[i] = ONE_Q16;
        end
        if (corm[i]) right_w[i] = add_sat(right_w[i], lambda);
        else miss_w[i] = add_sat(miss_w[i], lambda);
        if (selm[i]) continue;
        sum = longint'(miss_w[i]) + right_w[i];
        err = (sum == 0) ? ONE_Q16 : (longint'(miss_w[i]) << 16) / sum;
        if (err < min_err) begin
          min_err = err;
          best = i;
          best_ok = 1;
        end else if (err >= max_err) begin
          max_err = err;
          worst = i;
          worst_ok = 1;
        end
      end
      if (best_ok) begin
        d = corm[best] ? 2 * (ONE_Q16 - min_err) : 2 * min_err;
        if (d == 0) begin
          res.updated_importance = (lambda != 0) ? SAT32 : '0;
        end else begin
          q = (longint'(lambda) << 16) / d;
          res.updated_importance = (q > 64'hFFFF_FFFF) ? SAT32 : q[31:0];
        end
        vote_keep = vote_from_error(min_err);
        res.vote_weight = vote_keep;
        pick_keep = best[4:0];
      end
      res.best_index = best_ok ? best[4:0] : pick_keep;
      res.best_valid = best_ok;
      res.worst_index = worst_ok ? worst[4:0] : 5'd0;
      res.worst_valid = worst_ok;
      res.best_error = min_err[16:0];
      expected_q = {expected_q, res};
    endfunction

    function void check_round(round_result_t got);
      round_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.best_index !== want.best_index)
        $display("%0t: best_index expected %0d actual %0d", $realtime,
                 want.best_index, got.best_index);
      if (got.best_valid !== want.best_valid)
        $display("%0t: best_valid expected %0d actual %0d", $realtime,
                 want.best_valid, got.best_valid);
      if (got.worst_index !== want.worst_index)
        $display("%0t: worst_index expected %0d actual %0d", $realtime,
                 want.worst_index, got.worst_index);
      if (got.worst_valid !== want.worst_valid)
        $display("%0t: worst_valid expected %0d actual %0d", $realtime,
                 want.worst_valid, got.worst_valid);
      if (got.updated_importance !== want.updated_importance)
        $display("%0t: updated_importance expected %h actual %h", $realtime,
                 want.updated_importance, got.updated_importance);
      if (got.vote_weight !== want.vote_weight)
        $display("%0t: vote_weight expected %h actual %h", $realtime,
                 want.vote_weight, got.vote_weight);
      if (got.best_error !== want.best_error)
        $display("%0t: best_error expected %h actual %h", $realtime,
                 want.best_error, got.best_error);
      if (got !== want) errors++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_new_mask = '0;
  logic [31:0] in_correct_mask = '0;
  logic [31:0] in_selected_mask = '0;
  logic [31:0] in_importance = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_best_index;
  logic        out_best_valid;
  logic [4:0]  out_worst_index;
  logic        out_worst_valid;
  logic [31:0] out_updated_importance;
  logic [23:0] out_vote_weight;
  logic [16:0] out_best_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  round_tracker rounds = new();
  logic [31:0]  seeded_slots = '0;
  bit           calm = 0;

  online_boost_selector i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      rounds.check_round({out_best_index, out_best_valid, out_worst_index,
                          out_worst_valid, out_updated_importance,
                          out_vote_weight, out_best_error});
    out_ready <= calm || ($urandom_range(99) >= 29);
  end

  function automatic logic [31:0] slot_mask();
    int n;
    n = (rounds.slots > 32) ? 32 : rounds.slots;
    return (n == 32) ? SAT32 : ((32'd1 << n) - 1);
  endfunction

  task automatic drain();
    while (rounds.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_slots(logic [5:0] count);
    in_valid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rounds.slots = count;
    cfg_valid <= 1'b0;
  endtask

  // Slots that were never reset get their new bit forced, so no undefined
  // weight is ever read. The valid stays high after an accepted request until
  // the next request or an idle cycle replaces it.
  task automatic send_round(logic [31:0] newm, logic [31:0] corm,
                            logic [31:0] selm, logic [31:0] lambda);
    logic [31:0] forced;
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    forced = newm | (slot_mask() & ~seeded_slots);
    in_valid <= 1'b1;
    in_new_mask <= forced;
    in_correct_mask <= corm;
    in_selected_mask <= selm;
    in_importance <= lambda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rounds.note_round(forced, corm, selm, lambda);
    seeded_slots = seeded_slots | (forced & slot_mask());
  endtask

  function automatic logic [31:0] pick_importance();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return SAT32;
      2, 3: return $urandom;
      default: return $urandom_range(32'h0003_0000);
    endcase
  endfunction

  task automatic random_rounds(int count);
    logic [31:0] newm, selm;
    for (int k = 0; k < count; k++) begin
      newm = $urandom & $urandom & $urandom;
      if ($urandom_range(19) == 0) newm = $urandom;
      selm = $urandom & $urandom;
      case ($urandom_range(19))
        0: selm = SAT32;
        1: selm = '0;
        2: selm = $urandom;
        default: ;
      endcase
      send_round(newm, $urandom, selm, pick_importance());
    end
  endtask

  initial begin
    logic [5:0] phases [6] = '{6'd1, 6'd17, 6'd0, 6'd63, 6'd5, 6'd32};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_slots(6'd32);
    send_round(SAT32, SAT32, '0, ONE_Q16);
    send_round('0, '0, '0, ONE_Q16);
    send_round('0, SAT32, '0, SAT32);
    send_round('0, '0, '0, SAT32);
    send_round('0, 32'hAAAA_AAAA, '0, 32'd0);
    send_round('0, 32'h5555_5555, SAT32, 32'd1234);
    send_round(SAT32, '0, 32'h7FFF_FFFF, 32'd1);
    send_round('0, 32'h8000_0000, 32'hFFFF_FFFE, 32'h0000_8000);
    send_round(SAT32, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0002_0000);
    random_rounds(200);
    calm = 1;
    random_rounds(150);
    calm = 0;
    foreach (phases[p]) begin
      write_slots(phases[p]);
      random_rounds(90);
    end
    in_valid <= 1'b0;
    drain();
    repeat (1000) @(posedge clk);
    if (rounds.errors == 0 && rounds.expected_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
src/obs_pkg.sv
src/obs_ram.sv
src/obs_div.sv
src/obs_log.sv
src/online_boost_selector.sv
bench/testbench.sv
